### hw/rtl/cbq_pkg.sv
// Shared types and constants for the cascaded biquad filter core.
package cbq_pkg;

    // Filter structure
    localparam int TAPS             = 5;    // b0, b1, b2, a1, a2 per section
    localparam int GUARD            = 16;   // extra fraction bits in the state format
    localparam int COEF_INDEX_WIDTH = 6;
    localparam int SECTIONS_WIDTH   = 4;

    // Configuration register map
    localparam int CFG_ADDR_WIDTH = 1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_INPUT_GAIN      = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_ACTIVE_SECTIONS = 1'b1;

    // Request kinds on the input stream (tuser)
    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_FILTER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XSAT,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_A1,
        ST_A2,
        ST_WB,
        ST_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        MUL_HOLD,
        MUL_GAIN,
        MUL_COEF_X,
        MUL_COEF_Y
    } mul_sel_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_XSAT,
        OP_Y,
        OP_ACC1_INIT,
        OP_ACC2_INIT,
        OP_ACC1_SUB,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        dp_op_t   op;
    } dp_ctrl_t;

endpackage

### hw/rtl/cbq_coef_ram.sv
// Coefficient memory: one write port, one read port, registered read data.
module cbq_coef_ram #(
    parameter int DEPTH = 40,
    parameter int WIDTH = 18,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cbq_state_ram.sv
// Delay-state memory, one entry per section, reads as zero until first written.
module cbq_state_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // per-entry valid bits stand in for a clear of the array
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

### hw/rtl/cbq_mac.sv
// Shared multiply, round, accumulate and saturate datapath.
module cbq_mac
    import cbq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18,
    localparam int W = SAMPLE_WIDTH + GUARD
) (
    input  logic                           aclk,
    input  dp_ctrl_t                       ctrl,
    input  logic signed [COEF_WIDTH-1:0]   gain,
    input  logic signed [COEF_WIDTH-1:0]   coef,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [W-1:0]            d1,
    input  logic signed [W-1:0]            d2,
    output logic signed [W-1:0]            v1,
    output logic signed [W-1:0]            v2,
    output logic signed [SAMPLE_WIDTH-1:0] res_sample,
    output logic                           res_clip
);

    localparam int P = COEF_WIDTH + W;   // full product
    localparam int F = COEF_WIDTH - 2;   // coefficient fraction bits
    localparam int R = P - F;            // rounded product, W + 2
    localparam int A = W + 4;            // accumulator
    localparam logic signed [P-1:0] HALF_LSB = {{(P-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic [W:0] OUT_HALF = {{(W-GUARD+1){1'b0}}, 1'b1, {(GUARD-1){1'b0}}};

    logic signed [P-1:0] prod_reg;
    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic signed [A-1:0] acc1_reg;
    logic signed [A-1:0] acc2_reg;

    logic signed [COEF_WIDTH-1:0] mul_a;
    logic signed [W-1:0]          mul_b;
    logic signed [W-1:0]          sample_ext;
    logic signed [P-1:0]          prod_next;
    logic signed [P-1:0]          prod_biased;
    logic signed [R-1:0]          rp;
    logic signed [A-1:0]          rp_ext;
    logic signed [A-1:0]          d1_ext;
    logic signed [A-1:0]          d2_ext;
    logic signed [A-1:0]          y_sum;
    logic signed [A-1:0]          acc1_init;
    logic signed [A-1:0]          acc1_sub;
    logic signed [A-1:0]          v2_sum;
    logic [W:0]                   fin_sum;
    logic [SAMPLE_WIDTH:0]        fin_shift;

    function automatic logic signed [W-1:0] sat_state(input logic signed [A-1:0] v);
        logic signed [W-1:0] r;
        if (v[A-1:W-1] == {(A-W+1){v[A-1]}}) begin
            r = v[W-1:0];
        end else if (v[A-1]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    assign sample_ext = {sample, {GUARD{1'b0}}};

    always_comb begin
        mul_a = coef;
        mul_b = x_reg;
        case (ctrl.mul_sel)
            MUL_GAIN: begin
                mul_a = gain;
                mul_b = sample_ext;
            end
            MUL_COEF_Y: begin
                mul_b = y_reg;
            end
            default: begin
                mul_b = x_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round half up to the state format: add half an LSB, keep the high bits
    assign prod_biased = prod_reg + HALF_LSB;
    assign rp          = prod_biased[P-1:F];
    assign rp_ext      = {{(A-R){rp[R-1]}}, rp};
    assign d1_ext      = {{(A-W){d1[W-1]}}, d1};
    assign d2_ext      = {{(A-W){d2[W-1]}}, d2};

    assign y_sum     = d1_ext + rp_ext;
    assign acc1_init = d2_ext + rp_ext;
    assign acc1_sub  = acc1_reg - rp_ext;
    assign v2_sum    = acc2_reg - rp_ext;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_sel != MUL_HOLD) begin
            prod_reg <= prod_next;
        end
        case (ctrl.op)
            OP_XSAT:      x_reg    <= sat_state(rp_ext);
            OP_Y:         y_reg    <= sat_state(y_sum);
            OP_ACC1_INIT: acc1_reg <= acc1_init;
            OP_ACC2_INIT: acc2_reg <= rp_ext;
            OP_ACC1_SUB:  acc1_reg <= acc1_sub;
            OP_FINISH:    x_reg    <= y_reg;
            default: begin
            end
        endcase
    end

    assign v1 = sat_state(acc1_reg);
    assign v2 = sat_state(v2_sum);

    // final conversion to the sample format
    assign fin_sum    = {x_reg[W-1], x_reg} + OUT_HALF;
    assign fin_shift  = fin_sum[W:GUARD];
    assign res_clip   = fin_shift[SAMPLE_WIDTH] != fin_shift[SAMPLE_WIDTH-1];
    assign res_sample = !res_clip ? fin_shift[SAMPLE_WIDTH-1:0] :
                        fin_shift[SAMPLE_WIDTH] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} :
                                                  {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

endmodule

### hw/rtl/cascaded_biquad_iir_filter_core.sv
// Top level: cascade of transposed direct form II biquads around one shared MAC.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_addr (register), cfg_data (value)
//  s_axis  | in  | s_axis_tvalid / tready  | tdata: coef_index, coef_value, sample_in
//          |     |                         | tuser: action (0 load coef, 1 filter)
//  m_axis  | out | m_axis_tvalid / tready  | tdata: sample_out; tuser: clipped
//
//  A coefficient load request is taken while idle and leaves the core idle. A sample
//  keeps the core busy from acceptance until it is ready again; for each active
//  section (capped at MAX_SECTIONS) the one shared multiplier makes five products,
//  followed by one write-back step, plus the gain scaling and the output conversion.
//  Reset initialises the configuration, the sequencer and the delay-state valid bits at
//  once; there is no clearing pass. A stalled result sits in the output register;
//  the core keeps taking requests until a second result would need that register.
module cascaded_biquad_iir_filter_core
    import cbq_pkg::*;
#(
    parameter int MAX_SECTIONS = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18,
    localparam int IN_BITS     = COEF_INDEX_WIDTH + COEF_WIDTH + SAMPLE_WIDTH,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [COEF_WIDTH-1:0]     cfg_data,
    // requests
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_W-1:0]     s_axis_tdata,  // coef_index, coef_value, sample_in, pad
    input  logic                      s_axis_tuser,  // action
    // results
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_W-1:0]    m_axis_tdata,  // sample_out, pad
    output logic                      m_axis_tuser   // clipped
);

    localparam int SLOTS   = TAPS * MAX_SECTIONS;
    localparam int CA_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int STATE_W = SAMPLE_WIDTH + GUARD;
    localparam int VAL_LSB = COEF_INDEX_WIDTH;
    localparam int SMP_LSB = COEF_INDEX_WIDTH + COEF_WIDTH;
    localparam logic [COEF_WIDTH-1:0] GAIN_ONE = {2'b01, {(COEF_WIDTH-2){1'b0}}};
    localparam logic [COEF_INDEX_WIDTH:0] SLOTS_LIM = (COEF_INDEX_WIDTH+1)'(SLOTS);
    localparam logic [SECTIONS_WIDTH:0]   SEC_LIM   = (SECTIONS_WIDTH+1)'(MAX_SECTIONS);

    // configuration registers
    logic signed [COEF_WIDTH-1:0] gain_reg;
    logic [SECTIONS_WIDTH-1:0]    sections_reg;

    // sequencer
    seq_state_t       state_reg, state_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [CA_W-1:0]  ptr_reg, ptr_next;
    dp_ctrl_t         ctrl;
    logic             coef_re;
    logic             st_re;
    logic             st_we;
    logic             out_load;
    logic             in_ready;

    // output register
    logic                    m_valid_reg;
    logic [SAMPLE_WIDTH-1:0] m_sample_reg;
    logic                    m_clip_reg;

    // request decode
    logic [COEF_INDEX_WIDTH:0]  slot_ext;
    logic                       coef_we;
    logic [SECTIONS_WIDTH:0]    sec_wide;
    logic [SECTIONS_WIDTH:0]    n_used;
    logic [SECTIONS_WIDTH:0]    sec_plus1;
    logic                       more_sections;

    // memories and datapath
    logic [COEF_WIDTH-1:0]         coef_rdata;
    logic [2*STATE_W-1:0]          st_rdata;
    logic signed [STATE_W-1:0]     v1, v2;
    logic signed [SAMPLE_WIDTH-1:0] res_sample;
    logic                           res_clip;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_ONE;
            sections_reg <= SECTIONS_WIDTH'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_INPUT_GAIN:      gain_reg     <= cfg_data;
                REG_ACTIVE_SECTIONS: sections_reg <= cfg_data[SECTIONS_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // sections in use, capped at what the state memory holds
    assign sec_wide      = {1'b0, sections_reg};
    assign n_used        = (sec_wide > SEC_LIM) ? SEC_LIM : sec_wide;
    assign sec_plus1     = (SECTIONS_WIDTH+1)'(sec_reg) + (SECTIONS_WIDTH+1)'(1);
    assign more_sections = sec_plus1 < n_used;

    // coefficient loads go straight to memory; slots past the store are dropped
    assign slot_ext = {1'b0, s_axis_tdata[COEF_INDEX_WIDTH-1:0]};
    assign coef_we  = s_axis_tvalid && in_ready && (s_axis_tuser == ACTION_LOAD)
                      && (slot_ext < SLOTS_LIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Per section: coefficients stream out of memory in slot order, one a cycle,
    // each read in the state before the product that uses it.
    always_comb begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        ptr_next     = ptr_reg;
        ctrl.mul_sel = MUL_HOLD;
        ctrl.op      = OP_NONE;
        coef_re      = 1'b0;
        st_re        = 1'b0;
        st_we        = 1'b0;
        out_load     = 1'b0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_axis_tvalid && (s_axis_tuser == ACTION_FILTER)) begin
                    ctrl.mul_sel = MUL_GAIN;
                    sec_next     = '0;
                    ptr_next     = '0;
                    state_next   = ST_XSAT;
                end
            end
            ST_XSAT: begin
                ctrl.op = OP_XSAT;
                if (n_used == '0) begin
                    state_next = ST_OUT;
                end else begin
                    coef_re    = 1'b1;
                    st_re      = 1'b1;
                    ptr_next   = ptr_reg + CA_W'(1);
                    state_next = ST_B0;
                end
            end
            ST_B0: begin
                ctrl.mul_sel = MUL_COEF_X;
                coef_re      = 1'b1;
                ptr_next     = ptr_reg + CA_W'(1);
                state_next   = ST_B1;
            end
            ST_B1: begin
                ctrl.mul_sel = MUL_COEF_X;
                ctrl.op      = OP_Y;
                coef_re      = 1'b1;
                ptr_next     = ptr_reg + CA_W'(1);
                state_next   = ST_B2;
            end
            ST_B2: begin
                ctrl.mul_sel = MUL_COEF_X;
                ctrl.op      = OP_ACC1_INIT;
                coef_re      = 1'b1;
                ptr_next     = ptr_reg + CA_W'(1);
                state_next   = ST_A1;
            end
            ST_A1: begin
                ctrl.mul_sel = MUL_COEF_Y;
                ctrl.op      = OP_ACC2_INIT;
                coef_re      = 1'b1;
                ptr_next     = ptr_reg + CA_W'(1);
                state_next   = ST_A2;
            end
            ST_A2: begin
                ctrl.mul_sel = MUL_COEF_Y;
                ctrl.op      = OP_ACC1_SUB;
                state_next   = ST_WB;
            end
            ST_WB: begin
                ctrl.op = OP_FINISH;
                st_we   = 1'b1;
                if (more_sections) begin
                    sec_next   = sec_reg + SEC_W'(1);
                    coef_re    = 1'b1;
                    st_re      = 1'b1;
                    ptr_next   = ptr_reg + CA_W'(1);
                    state_next = ST_B0;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = in_ready;

    cbq_coef_ram #(
        .DEPTH (SLOTS),
        .WIDTH (COEF_WIDTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (slot_ext[CA_W-1:0]),
        .wdata (s_axis_tdata[VAL_LSB +: COEF_WIDTH]),
        .re    (coef_re),
        .raddr (ptr_reg),
        .rdata (coef_rdata)
    );

    // state entry: {v2, v1}; the next section's read overlaps this one's write
    cbq_state_ram #(
        .DEPTH (MAX_SECTIONS),
        .WIDTH (2 * STATE_W)
    ) u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (st_we),
        .waddr   (sec_reg),
        .wdata   ({v2, v1}),
        .re      (st_re),
        .raddr   (sec_next),
        .rdata   (st_rdata)
    );

    cbq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .gain       (gain_reg),
        .coef       (coef_rdata),
        .sample     (s_axis_tdata[SMP_LSB +: SAMPLE_WIDTH]),
        .d1         (st_rdata[STATE_W-1:0]),
        .d2         (st_rdata[2*STATE_W-1:STATE_W]),
        .v1         (v1),
        .v2         (v2),
        .res_sample (res_sample),
        .res_clip   (res_clip)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sample_reg <= res_sample;
            m_clip_reg   <= res_clip;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_sample_reg);
    assign m_axis_tuser  = m_clip_reg;

    // a sample request keeps the core busy on the next cycle
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACTION_FILTER))
        |=> !s_axis_tready)
        else $error("core ready right after a sample request");

    // a coefficient load never starts the sequencer
    a_load_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACTION_LOAD))
        |=> (state_reg == ST_IDLE))
        else $error("coefficient load left idle");

    // section counter stays inside the active range while a section runs
    a_section_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_XSAT && state_reg != ST_OUT)
        |-> (sec_plus1 <= n_used))
        else $error("section counter beyond active sections");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_OUT))
        else $error("result register reloaded while stalled");

endmodule

### tb/cascaded_biquad_iir_filter_checker.sv
`timescale 1ns / 1ps
// Stream checker for the biquad cascade core: tracks its state, predicts each output, compares.
module cascaded_biquad_iir_filter_checker
    import cbq_pkg::*;
#(
    parameter int MAX_SECTIONS = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18,
    localparam int IN_TDATA_W  = ((COEF_INDEX_WIDTH + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [COEF_WIDTH-1:0]     cfg_data,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [IN_TDATA_W-1:0]     s_axis_tdata,  // coef_index, coef_value, sample_in, pad
    input  logic                      s_axis_tuser,  // action
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]    m_axis_tdata,  // sample_out, pad
    input  logic                      m_axis_tuser,  // clipped
    output int                        mismatch_count,
    output int                        samples_outstanding
);

    localparam int COEF_FRAC   = COEF_WIDTH - 2;
    localparam int STATE_WIDTH = SAMPLE_WIDTH + GUARD;
    localparam int SLOTS       = TAPS * MAX_SECTIONS;
    localparam int VALUE_LSB   = COEF_INDEX_WIDTH;
    localparam int SAMPLE_LSB  = COEF_INDEX_WIDTH + COEF_WIDTH;

    // tap order inside one section
    localparam int TAP_B0 = 0;
    localparam int TAP_B1 = 1;
    localparam int TAP_B2 = 2;
    localparam int TAP_A1 = 3;
    localparam int TAP_A2 = 4;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample;
        logic                    clipped;
    } filtered_t;

    logic signed [COEF_WIDTH-1:0]  gain_q;
    logic [SECTIONS_WIDTH-1:0]     sections_q;
    logic signed [COEF_WIDTH-1:0]  coef_mem [SLOTS];
    logic signed [STATE_WIDTH-1:0] delay1 [MAX_SECTIONS];
    logic signed [STATE_WIDTH-1:0] delay2 [MAX_SECTIONS];
    filtered_t                     expected_samples [$];

    // round half up, then arithmetic shift (floor)
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint saturate(longint v, int w, inout bit hit);
        longint lim;
        lim = longint'(1) <<< (w - 1);
        if (v >= lim) begin
            hit = 1'b1;
            return lim - 1;
        end
        if (v < -lim) begin
            hit = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    function automatic longint coef_scale(logic signed [COEF_WIDTH-1:0] c, longint sig);
        return round_shift(longint'(c) * sig, COEF_FRAC);
    endfunction

    // One sample through gain and the active sections; updates the delay line.
    function automatic filtered_t filter_sample(logic signed [SAMPLE_WIDTH-1:0] smp);
        filtered_t res;
        longint    x, y, v1, v2, o;
        int        n, base, j;
        bit        hit;
        hit = 1'b0;
        x = longint'(smp) <<< GUARD;
        x = saturate(round_shift(longint'(gain_q) * x, COEF_FRAC), STATE_WIDTH, hit);
        n = (sections_q > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections_q);
        for (j = 0; j < n; j++) begin
            base = j * TAPS;
            y  = saturate(longint'(delay1[j]) + coef_scale(coef_mem[base + TAP_B0], x),
                          STATE_WIDTH, hit);
            v1 = saturate(longint'(delay2[j]) - coef_scale(coef_mem[base + TAP_A1], y)
                          + coef_scale(coef_mem[base + TAP_B1], x), STATE_WIDTH, hit);
            v2 = saturate(coef_scale(coef_mem[base + TAP_B2], x)
                          - coef_scale(coef_mem[base + TAP_A2], y), STATE_WIDTH, hit);
            delay1[j] = v1[STATE_WIDTH-1:0];
            delay2[j] = v2[STATE_WIDTH-1:0];
            x = y;
        end
        // only the final conversion drives the clip flag
        hit = 1'b0;
        o = saturate(round_shift(x, GUARD), SAMPLE_WIDTH, hit);
        res.sample  = o[SAMPLE_WIDTH-1:0];
        res.clipped = hit;
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        filtered_t               want;
        logic [SAMPLE_WIDTH-1:0] got_sample;
        logic [COEF_INDEX_WIDTH-1:0] slot;
        if (!aresetn) begin
            gain_q     = COEF_WIDTH'(1 << COEF_FRAC);
            sections_q = SECTIONS_WIDTH'(1);
            for (int k = 0; k < MAX_SECTIONS; k++) begin
                delay1[k] = '0;
                delay2[k] = '0;
            end
            expected_samples.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_INPUT_GAIN:      gain_q = cfg_data;
                    REG_ACTIVE_SECTIONS: sections_q = cfg_data[SECTIONS_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got_sample = m_axis_tdata[SAMPLE_WIDTH-1:0];
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected output: sample_out %0d clipped %0b",
                             $time, $signed(got_sample), m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (got_sample !== want.sample) begin
                        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.sample), $signed(got_sample));
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.clipped) begin
                        $display("%0t: clipped mismatch: expected %0b, actual %0b",
                                 $time, want.clipped, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ACTION_FILTER) begin
                    expected_samples.push_back(
                        filter_sample(s_axis_tdata[SAMPLE_LSB +: SAMPLE_WIDTH]));
                end else begin
                    slot = s_axis_tdata[0 +: COEF_INDEX_WIDTH];
                    if (slot < SLOTS)
                        coef_mem[slot] = s_axis_tdata[VALUE_LSB +: COEF_WIDTH];
                end
            end
        end
        samples_outstanding <= expected_samples.size();
    end

endmodule

### tb/cascaded_biquad_iir_filter_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the biquad cascade core: reset, stimulus, backpressure and the verdict.
module cascaded_biquad_iir_filter_core_test;
    import cbq_pkg::*;

    localparam int MAX_SECTIONS = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 18;
    localparam int IN_TDATA_W   = ((COEF_INDEX_WIDTH + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SLOTS        = TAPS * MAX_SECTIONS;
    localparam int TOP_SLOT     = (1 << COEF_INDEX_WIDTH) - 1;

    // Q2.16 and Q1.15 landmarks
    localparam int COEF_ONE = 1 << (COEF_WIDTH - 2);
    localparam int COEF_MAX = (1 << (COEF_WIDTH - 1)) - 1;
    localparam int COEF_MIN = -(1 << (COEF_WIDTH - 1));
    localparam int SMP_MAX  = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam int SMP_MIN  = -(1 << (SAMPLE_WIDTH - 1));

    // section 0 slots used by the directed part
    localparam int SLOT_B0 = 0;
    localparam int SLOT_A1 = 3;

    localparam int RANDOM_ITEMS = 1500;
    // room for a sample through all MAX_SECTIONS sections, and for a trailing load too
    localparam int SETTLE_CYCLES = 64;
    localparam int RUN_LIMIT_CYCLES = 1_000_000;

    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready a quarter of the time on average
        RX_BURSTY   // long stall, short open window
    } rx_mode_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr      = '0;
    logic [COEF_WIDTH-1:0]     cfg_data      = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata  = '0;  // coef_index, coef_value, sample_in, pad
    logic                      s_axis_tuser  = 1'b0;  // action
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;  // sample_out, pad
    logic                      m_axis_tuser;  // clipped

    int mismatch_count;
    int samples_outstanding;

    // sender bookkeeping (blocking, owned by the stimulus process)
    bit stream_busy = 1'b0;   // mirrors s_axis_tvalid without reading it back
    bit gaps_on     = 1'b0;
    int burst_left  = 0;
    int item_count  = 0;
    bit coef_written [SLOTS];

    rx_mode_t   rx_mode    = RX_OPEN;
    logic [7:0] stall_tick = '0;

    always #10 aclk = ~aclk;

    cascaded_biquad_iir_filter_core #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cascaded_biquad_iir_filter_checker #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_addr            (cfg_addr),
        .cfg_data            (cfg_data),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .mismatch_count      (mismatch_count),
        .samples_outstanding (samples_outstanding)
    );

    // Result side backpressure. The mode is re-rolled whenever stall_tick[6:0] wraps, so runs
    // of full throughput alternate with light, heavy and long periodic stalls.
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick[6:0] == 7'd0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= (stall_tick[4:0] >= 5'd27);
        endcase
    end

    // Present one request and hold it until the core takes it. Afterwards the
    // sender either keeps tvalid up for the next request of the burst or drops
    // it for a random gap. tvalid is touched at most once per clock edge.
    task automatic send_request(input logic                        action,
                                input logic [COEF_INDEX_WIDTH-1:0] idx,
                                input logic [COEF_WIDTH-1:0]       value,
                                input logic [SAMPLE_WIDTH-1:0]     smp);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[0 +: COEF_INDEX_WIDTH]                         = idx;
        word[COEF_INDEX_WIDTH +: COEF_WIDTH]                = value;
        word[COEF_INDEX_WIDTH + COEF_WIDTH +: SAMPLE_WIDTH] = smp;
        s_axis_tdata  <= word;
        s_axis_tuser  <= action;
        s_axis_tvalid <= 1'b1;
        stream_busy    = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            stream_busy    = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Coefficient load request; the unused sample field carries noise.
    task automatic load_coef(input int slot, input logic [COEF_WIDTH-1:0] value);
        if (slot < SLOTS) begin
            coef_written[slot] = 1'b1;
            item_count++;
        end
        send_request(ACTION_LOAD, COEF_INDEX_WIDTH'(slot), value, SAMPLE_WIDTH'($urandom));
    endtask

    // Filter request; the unused coefficient fields carry noise.
    task automatic filter(input logic [SAMPLE_WIDTH-1:0] smp);
        item_count++;
        send_request(ACTION_FILTER, COEF_INDEX_WIDTH'($urandom), COEF_WIDTH'($urandom), smp);
    endtask

    // Stop sending until every predicted sample is out, then let a possible
    // trailing coefficient load finish inside the core.
    task automatic hold_until_drained();
        if (stream_busy) begin
            s_axis_tvalid <= 1'b0;
            stream_busy    = 1'b0;
        end
        @(posedge aclk);
        while (samples_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers, back to back with cfg_valid held high. Only called idle.
    // Upper bits of the section count write are noise; the core keeps 4 bits.
    task automatic write_config(input logic [COEF_WIDTH-1:0]     gain,
                                input logic [SECTIONS_WIDTH-1:0] secs);
        logic [COEF_WIDTH-1:0] word;
        word = COEF_WIDTH'($urandom);
        word[SECTIONS_WIDTH-1:0] = secs;
        cfg_addr  <= REG_INPUT_GAIN;
        cfg_data  <= gain;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_addr <= REG_ACTIVE_SECTIONS;
        cfg_data <= word;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Tame coefficients (|c| <= 0.25) keep the cascade stable so real filtering
    // shows up; wild ones exercise saturation of states and output.
    function automatic logic [COEF_WIDTH-1:0] pick_coef(bit tame);
        if (tame)
            return COEF_WIDTH'(int'($urandom_range(0, COEF_ONE / 2)) - COEF_ONE / 4);
        return COEF_WIDTH'($urandom);
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_WIDTH'(SMP_MAX);
            1:       return SAMPLE_WIDTH'(SMP_MIN);
            2, 3:    return SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    initial begin
        int                        phase;
        int                        n;
        int                        k;
        int                        len;
        int                        pick;
        bit                        tame;
        logic [COEF_WIDTH-1:0]     gain;
        logic [SECTIONS_WIDTH-1:0] secs;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset configuration: gain 1.0, one section.
        // Section 0 as a straight wire.
        load_coef(SLOT_B0, COEF_WIDTH'(COEF_ONE));
        for (k = SLOT_B0 + 1; k < TAPS; k++)
            load_coef(k, '0);
        // slots past the last section are ignored
        load_coef(TOP_SLOT, COEF_WIDTH'(COEF_MAX));
        load_coef(SLOTS, COEF_WIDTH'(COEF_MIN));
        filter(SAMPLE_WIDTH'(SMP_MAX));
        filter(SAMPLE_WIDTH'(SMP_MIN));
        filter('0);
        filter(SAMPLE_WIDTH'(1));
        filter('1);
        // b0 = -2.0: both sample extremes clip at the output
        load_coef(SLOT_B0, COEF_WIDTH'(COEF_MIN));
        filter(SAMPLE_WIDTH'(SMP_MAX));
        filter(SAMPLE_WIDTH'(SMP_MIN));
        // largest positive b0
        load_coef(SLOT_B0, COEF_WIDTH'(COEF_MAX));
        filter(SAMPLE_WIDTH'(SMP_MAX));
        // a1 = -2.0 makes the loop run away: delay states saturate
        load_coef(SLOT_B0, COEF_WIDTH'(COEF_ONE));
        load_coef(SLOT_A1, COEF_WIDTH'(COEF_MIN));
        repeat (3) filter(SAMPLE_WIDTH'(SMP_MAX));
        hold_until_drained();

        // Random phases: each one sets gain and section count while idle, fills
        // any slot the new section count would read before it was ever written,
        // then streams mostly samples mixed with coefficient loads.
        item_count = 0;
        phase = 0;
        while (item_count < RANDOM_ITEMS) begin
            case (phase)
                0: begin  // zero sections: output is the scaled sample, gain near +2
                    gain = COEF_WIDTH'(COEF_MAX);
                    secs = '0;
                end
                1: begin  // count above MAX_SECTIONS is capped, gain -2
                    gain = COEF_WIDTH'(COEF_MIN);
                    secs = '1;
                end
                2: begin
                    gain = '0;
                    secs = SECTIONS_WIDTH'(MAX_SECTIONS);
                end
                default: begin
                    pick = $urandom_range(0, 3);
                    case (pick)
                        0:       gain = COEF_WIDTH'($urandom);
                        1:       gain = COEF_WIDTH'(COEF_ONE + int'($urandom_range(0, 8192))
                                                    - 4096);
                        2:       gain = COEF_WIDTH'($urandom_range(0, COEF_ONE));
                        default: gain = COEF_WIDTH'(COEF_ONE);
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        secs = SECTIONS_WIDTH'($urandom_range(0, (1 << SECTIONS_WIDTH) - 1));
                    else
                        secs = SECTIONS_WIDTH'($urandom_range(1, MAX_SECTIONS));
                end
            endcase
            write_config(gain, secs);

            tame       = ($urandom_range(0, 2) != 0);
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = 0;

            n = (secs > MAX_SECTIONS) ? MAX_SECTIONS : int'(secs);
            for (k = 0; k < n * TAPS; k++) begin
                if (!coef_written[k])
                    load_coef(k, pick_coef(tame));
            end

            len = $urandom_range(40, 200);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 84)
                    filter(pick_sample());
                else if (pick < 95)
                    load_coef($urandom_range(0, SLOTS - 1), pick_coef(tame));
                else if (pick < 98)
                    load_coef($urandom_range(SLOTS, TOP_SLOT), COEF_WIDTH'($urandom));
                else
                    hold_until_drained();  // let the pipeline run dry mid-phase
            end
            hold_until_drained();
            phase++;
        end

        if (mismatch_count == 0)
            $display("cascaded_biquad_iir_filter_core_test: PASS");
        else
            $display("cascaded_biquad_iir_filter_core_test: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge aclk);
        $display("cascaded_biquad_iir_filter_core_test: FAIL");
        $finish;
    end

endmodule
